/* hw/rtl/mhg_pkg.sv */
// Package with the shared types, constants and the helper function of the grid cell map.
package mhg_pkg;

  localparam int unsigned CAPACITY   = 4096;
  localparam int unsigned INDEX_BITS = 16;
  localparam int unsigned ADDR_W     = $clog2(CAPACITY);
  localparam int unsigned CNT_W      = $clog2(CAPACITY + 1);

  // Shared divider geometry: the level dividend needs 42 bits, the divisor 34.
  localparam int unsigned DIV_DW = 42;
  localparam int unsigned DIV_VW = 34;
  localparam int unsigned DIV_CW = $clog2(DIV_DW);

  localparam logic [3:0]  TOL_LSB       = 4'd7;
  localparam logic [32:0] MIN_RANGE     = 33'd66;
  localparam logic [20:0] SMALL_CELL    = 21'd7;
  localparam logic [20:0] FALLBACK_CELL = 21'd3277;
  localparam logic [12:0] RESET_MAX_CELLS = 13'd4096;
  localparam logic [6:0]  LEVEL_SCALE   = 7'd100;
  localparam logic signed [7:0] LEVEL_NONE = -8'sd1;

  typedef enum logic [1:0] {
    FN_INSERT = 2'd0,
    FN_QUERY  = 2'd1,
    FN_CLEAR  = 2'd2,
    FN_SPARE  = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    ST_UPDATED = 3'd0,
    ST_KEPT    = 3'd1,
    ST_DROPPED = 3'd2,
    ST_MISS    = 3'd3,
    ST_HIT     = 3'd4,
    ST_CLEARED = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    CFG_CELL_SIZE     = 2'd0,
    CFG_MAX_CELLS     = 2'd1,
    CFG_DEFAULT_COLOR = 2'd2,
    CFG_UNUSED        = 2'd3
  } cfg_idx_e;

  typedef enum logic [3:0] {
    S_IDLE, S_XSTART, S_XWAIT, S_YSTART, S_YWAIT, S_SCAN,
    S_UPDATE, S_LMUL, S_LSTART, S_LWAIT, S_DONE
  } fsm_e;

  typedef struct packed {
    logic [1:0]         func;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic [31:0]        point_color;
    logic [63:0]        source_node;
    logic signed [15:0] query_ix;
    logic signed [15:0] query_iy;
  } req_t;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [15:0] cell_ix;
    logic signed [15:0] cell_iy;
    logic signed [7:0]  level;
    logic signed [31:0] cell_height;
    logic [31:0]        cell_color;
    logic [63:0]        cell_node;
    logic [12:0]        cell_count;
    logic signed [31:0] height_min;
    logic signed [31:0] height_max;
  } rsp_t;

  typedef struct packed {
    logic signed [INDEX_BITS-1:0] ix;
    logic signed [INDEX_BITS-1:0] iy;
    logic signed [31:0]           height;
    logic [31:0]                  color;
    logic [63:0]                  node;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  // Turns a magnitude quotient and the sign of the coordinate into a saturated
  // floor index.
  function automatic logic signed [INDEX_BITS-1:0] grid_index(
    input logic neg, input logic [31:0] q, input logic rem_nz);
    logic [32:0] mag;
    logic [32:0] lim;
    logic signed [INDEX_BITS-1:0] res;
    mag = {1'b0, q} + {32'd0, (neg & rem_nz)};
    lim = 33'(2 ** (INDEX_BITS - 1));
    if (!neg) begin
      if (mag >= lim) res = INDEX_BITS'(lim - 33'd1);
      else            res = INDEX_BITS'(mag);
    end else begin
      if (mag >= lim) res = INDEX_BITS'(lim);
      else            res = INDEX_BITS'(33'd0 - mag);
    end
    return res;
  endfunction

endpackage

/* hw/rtl/mhg_ram.sv */
// Generic single write port, single read port RAM with a registered read.
module mhg_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and registered read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/mhg_div.sv */
// Restoring unsigned divider that produces one quotient bit a cycle.
module mhg_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [mhg_pkg::DIV_DW-1:0] dividend_i,
  input  logic [mhg_pkg::DIV_VW-1:0] divisor_i,
  output logic                      done_o,
  output logic [mhg_pkg::DIV_DW-1:0] quot_o,
  output logic [mhg_pkg::DIV_VW-1:0] rem_o
);

  logic [mhg_pkg::DIV_DW-1:0] quo_q;
  logic [mhg_pkg::DIV_VW-1:0] rem_q;
  logic [mhg_pkg::DIV_VW-1:0] div_q;
  logic [mhg_pkg::DIV_CW-1:0] cnt_q;
  logic                       busy_q;
  logic                       done_q;
  logic [mhg_pkg::DIV_VW:0]   shift;
  logic [mhg_pkg::DIV_VW:0]   diff;
  logic                       ge;

  // One trial subtraction per cycle.
  always_comb begin
    shift = {rem_q, quo_q[mhg_pkg::DIV_DW-1]};
    diff  = shift - {1'b0, div_q};
    ge    = shift >= {1'b0, div_q};
  end

  // Control of the iteration count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= mhg_pkg::DIV_CW'(mhg_pkg::DIV_DW - 1);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  // Datapath of the partial remainder and quotient.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[mhg_pkg::DIV_VW-1:0] : shift[mhg_pkg::DIV_VW-1:0];
      quo_q <= {quo_q[mhg_pkg::DIV_DW-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;
  assign rem_o  = rem_q;

endmodule

/* hw/rtl/max_height_grid_cell_map.sv */
// Top level of the max-height grid cell map: control, cell store and output register.
// One request is in work at a time. The time from acceptance to result grows with the number
// of cells held, and output stalls add to it; a clear needs no scan and no division.
// The time is set by the shared one-bit-per-cycle divider (two grid indices and the
// level) and by the key scan, which reads one cell a cycle through the single RAM port.
// Reset loads the register defaults and empties the map at once through the fill count;
// the cell RAM itself is not cleared and needs no clearing pass.
module max_height_grid_cell_map (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  mhg_pkg::req_t       in_req_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output mhg_pkg::rsp_t       out_rsp_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [1:0]          cfg_index_i,
  input  logic [31:0]         cfg_data_i
);

  mhg_pkg::fsm_e  state_q, state_d;
  mhg_pkg::req_t  req_q;
  mhg_pkg::entry_t cur_q, cur_d;
  mhg_pkg::rsp_t  out_q;
  logic           out_valid_q;

  logic signed [mhg_pkg::INDEX_BITS-1:0] ix_q, ix_d, iy_q, iy_d;
  logic [mhg_pkg::CNT_W-1:0]  scan_q, scan_d, used_q, used_d;
  logic [mhg_pkg::ADDR_W-1:0] raddr_q, kidx_q, kidx_d;
  logic        rvalid_q, rvalid_d, hit_q, hit_d, show_q, show_d;
  logic [2:0]  status_q, status_d;
  logic signed [7:0]  lvl_q, lvl_d;
  logic signed [31:0] lo_q, lo_d, hi_q, hi_d;
  logic [39:0] prod_q, prod_d;
  logic [32:0] range_q, range_d;
  logic [20:0] cs_q;
  logic [12:0] mc_q;
  logic [31:0] dc_q;

  logic        issue, match, full, repl, accept;
  logic [20:0] cell_eff;
  logic [31:0] mag;
  logic signed [31:0] coord;
  logic signed [32:0] hdiff, rdiff, zdiff;

  logic        div_start, div_done;
  logic [mhg_pkg::DIV_DW-1:0] div_dividend, div_quot;
  logic [mhg_pkg::DIV_VW-1:0] div_divisor, div_rem;

  logic        ram_we;
  logic [mhg_pkg::ADDR_W-1:0] ram_waddr;
  mhg_pkg::entry_t ram_wdata, ram_rdata;

  mhg_ram #(
    .WIDTH(mhg_pkg::ENTRY_W),
    .DEPTH(mhg_pkg::CAPACITY)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(scan_q[mhg_pkg::ADDR_W-1:0]),
    .rdata_o(ram_rdata)
  );

  mhg_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(div_dividend),
    .divisor_i (div_divisor),
    .done_o    (div_done),
    .quot_o    (div_quot),
    .rem_o     (div_rem)
  );

  assign accept      = in_valid_i && !in_stall_o;
  assign in_stall_o  = (state_q != mhg_pkg::S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cs_q <= mhg_pkg::FALLBACK_CELL;
      mc_q <= mhg_pkg::RESET_MAX_CELLS;
      dc_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (mhg_pkg::cfg_idx_e'(cfg_index_i))
        mhg_pkg::CFG_CELL_SIZE:     cs_q <= cfg_data_i[20:0];
        mhg_pkg::CFG_MAX_CELLS:     mc_q <= cfg_data_i[12:0];
        mhg_pkg::CFG_DEFAULT_COLOR: dc_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Shared signals of the datapath.
  always_comb begin
    cell_eff = (cs_q < mhg_pkg::SMALL_CELL) ? mhg_pkg::FALLBACK_CELL : cs_q;
    coord    = (state_q == mhg_pkg::S_XSTART || state_q == mhg_pkg::S_XWAIT)
               ? req_q.point_x : req_q.point_y;
    mag      = coord[31] ? (32'd0 - coord) : coord;
    issue    = (scan_q < used_q);
    match    = rvalid_q && (ram_rdata.ix == ix_q) && (ram_rdata.iy == iy_q);
    full     = (used_q >= mc_q) || (used_q >= mhg_pkg::CNT_W'(mhg_pkg::CAPACITY));
    zdiff    = {req_q.point_z[31], req_q.point_z} - {cur_q.height[31], cur_q.height};
    repl     = (zdiff > 33'sd7) ||
               ((zdiff >= -33'sd7) && (req_q.source_node >= cur_q.node));
    hdiff    = {cur_q.height[31], cur_q.height} - {lo_q[31], lo_q};
    rdiff    = {hi_q[31], hi_q} - {lo_q[31], lo_q};
  end

  // Next state and datapath control.
  always_comb begin
    state_d  = state_q;
    ix_d     = ix_q;
    iy_d     = iy_q;
    scan_d   = scan_q;
    rvalid_d = 1'b0;
    kidx_d   = kidx_q;
    hit_d    = hit_q;
    cur_d    = cur_q;
    status_d = status_q;
    lvl_d    = lvl_q;
    show_d   = show_q;
    used_d   = used_q;
    lo_d     = lo_q;
    hi_d     = hi_q;
    prod_d   = prod_q;
    range_d  = range_q;
    div_start    = 1'b0;
    div_dividend = {10'd0, mag};
    div_divisor  = {13'd0, cell_eff};
    ram_we    = 1'b0;
    ram_waddr = kidx_q;
    ram_wdata = cur_q;

    unique case (state_q)
      mhg_pkg::S_IDLE: begin
        if (accept) begin
          ix_d   = in_req_i.query_ix;
          iy_d   = in_req_i.query_iy;
          scan_d = '0;
          unique case (mhg_pkg::func_e'(in_req_i.func))
            mhg_pkg::FN_INSERT: state_d = mhg_pkg::S_XSTART;
            mhg_pkg::FN_CLEAR: begin
              ix_d     = '0;
              iy_d     = '0;
              used_d   = '0;
              lo_d     = 32'sh7FFF_FFFF;
              hi_d     = 32'sh8000_0000;
              status_d = mhg_pkg::ST_CLEARED;
              lvl_d    = '0;
              show_d   = 1'b0;
              state_d  = mhg_pkg::S_DONE;
            end
            default: state_d = mhg_pkg::S_SCAN;
          endcase
        end
      end
      mhg_pkg::S_XSTART: begin
        div_start = 1'b1;
        state_d   = mhg_pkg::S_XWAIT;
      end
      mhg_pkg::S_XWAIT: begin
        if (div_done) begin
          ix_d    = mhg_pkg::grid_index(req_q.point_x[31], div_quot[31:0], |div_rem);
          state_d = mhg_pkg::S_YSTART;
        end
      end
      mhg_pkg::S_YSTART: begin
        div_start = 1'b1;
        state_d   = mhg_pkg::S_YWAIT;
      end
      mhg_pkg::S_YWAIT: begin
        if (div_done) begin
          iy_d    = mhg_pkg::grid_index(req_q.point_y[31], div_quot[31:0], |div_rem);
          state_d = mhg_pkg::S_SCAN;
        end
      end
      mhg_pkg::S_SCAN: begin
        // One read issued per cycle; the data of the previous read is compared.
        rvalid_d = issue;
        if (issue) scan_d = scan_q + 1'b1;
        if (match) begin
          cur_d  = ram_rdata;
          kidx_d = raddr_q;
          hit_d  = 1'b1;
          if (req_q.func == mhg_pkg::FN_INSERT) begin
            state_d = mhg_pkg::S_UPDATE;
          end else begin
            status_d = mhg_pkg::ST_HIT;
            show_d   = 1'b1;
            state_d  = mhg_pkg::S_LMUL;
          end
        end else if (!issue && !rvalid_q) begin
          hit_d = 1'b0;
          if (req_q.func == mhg_pkg::FN_INSERT) begin
            state_d = mhg_pkg::S_UPDATE;
          end else begin
            status_d = mhg_pkg::ST_MISS;
            lvl_d    = mhg_pkg::LEVEL_NONE;
            show_d   = 1'b0;
            state_d  = mhg_pkg::S_DONE;
          end
        end
      end
      mhg_pkg::S_UPDATE: begin
        show_d = 1'b1;
        if (!hit_q && full) begin
          status_d = mhg_pkg::ST_DROPPED;
          lvl_d    = mhg_pkg::LEVEL_NONE;
          show_d   = 1'b0;
          state_d  = mhg_pkg::S_DONE;
        end else begin
          if (!hit_q) begin
            cur_d.ix     = ix_q;
            cur_d.iy     = iy_q;
            cur_d.height = req_q.point_z;
            cur_d.node   = req_q.source_node;
            cur_d.color  = (req_q.point_color != '0) ? req_q.point_color : dc_q;
            ram_we    = 1'b1;
            ram_waddr = used_q[mhg_pkg::ADDR_W-1:0];
            used_d    = used_q + 1'b1;
            status_d  = mhg_pkg::ST_UPDATED;
          end else if (repl) begin
            cur_d.height = req_q.point_z;
            cur_d.node   = req_q.source_node;
            if (req_q.point_color != '0) cur_d.color = req_q.point_color;
            else if (cur_q.color == '0)  cur_d.color = dc_q;
            ram_we    = 1'b1;
            ram_waddr = kidx_q;
            status_d  = mhg_pkg::ST_UPDATED;
          end else begin
            status_d = mhg_pkg::ST_KEPT;
          end
          ram_wdata = cur_d;
          if (req_q.point_z < lo_q) lo_d = req_q.point_z;
          if (req_q.point_z > hi_q) hi_d = req_q.point_z;
          state_d = mhg_pkg::S_LMUL;
        end
      end
      mhg_pkg::S_LMUL: begin
        range_d = (rdiff < $signed(mhg_pkg::MIN_RANGE)) ? mhg_pkg::MIN_RANGE : rdiff[32:0];
        prod_d  = 40'(hdiff[32:0]) * 40'(mhg_pkg::LEVEL_SCALE);
        if (hdiff <= 33'sd0) begin
          lvl_d   = '0;
          state_d = mhg_pkg::S_DONE;
        end else begin
          state_d = mhg_pkg::S_LSTART;
        end
      end
      mhg_pkg::S_LSTART: begin
        // Round half up: (2 * num + range) / (2 * range).
        div_start    = 1'b1;
        div_dividend = {1'b0, prod_q, 1'b0} + {9'd0, range_q};
        div_divisor  = {range_q, 1'b0};
        state_d      = mhg_pkg::S_LWAIT;
      end
      mhg_pkg::S_LWAIT: begin
        if (div_done) begin
          lvl_d   = (div_quot > mhg_pkg::DIV_DW'(mhg_pkg::LEVEL_SCALE))
                    ? 8'(mhg_pkg::LEVEL_SCALE) : 8'(div_quot[6:0]);
          state_d = mhg_pkg::S_DONE;
        end
      end
      mhg_pkg::S_DONE: begin
        if (!out_valid_q || !out_stall_i) state_d = mhg_pkg::S_IDLE;
      end
      default: state_d = mhg_pkg::S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mhg_pkg::S_IDLE;
      used_q      <= '0;
      lo_q        <= 32'sh7FFF_FFFF;
      hi_q        <= 32'sh8000_0000;
      rvalid_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      used_q   <= used_d;
      lo_q     <= lo_d;
      hi_q     <= hi_d;
      rvalid_q <= rvalid_d;
      if (state_q == mhg_pkg::S_DONE && state_d == mhg_pkg::S_IDLE) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (accept) req_q <= in_req_i;
    ix_q     <= ix_d;
    iy_q     <= iy_d;
    scan_q   <= scan_d;
    raddr_q  <= scan_q[mhg_pkg::ADDR_W-1:0];
    kidx_q   <= kidx_d;
    hit_q    <= hit_d;
    cur_q    <= cur_d;
    status_q <= status_d;
    lvl_q    <= lvl_d;
    show_q   <= show_d;
    prod_q   <= prod_d;
    range_q  <= range_d;
    if (state_q == mhg_pkg::S_DONE && state_d == mhg_pkg::S_IDLE) begin
      out_q.status      <= status_q;
      out_q.cell_ix     <= ix_q;
      out_q.cell_iy     <= iy_q;
      out_q.level       <= lvl_q;
      out_q.cell_height <= show_q ? cur_q.height : '0;
      out_q.cell_color  <= show_q ? cur_q.color : '0;
      out_q.cell_node   <= show_q ? cur_q.node : '0;
      out_q.cell_count  <= used_q;
      out_q.height_min  <= lo_q;
      out_q.height_max  <= hi_q;
    end
  end

  // The fill count never passes the capacity.
  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= mhg_pkg::CNT_W'(mhg_pkg::CAPACITY))
    else $error("cell count beyond capacity");

  // The cell store is written only while a cell is being updated.
  a_write_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> state_q == mhg_pkg::S_UPDATE)
    else $error("cell store written outside the update step");

  // The divider finishes only while the controller waits for it.
  a_div_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == mhg_pkg::S_XWAIT || state_q == mhg_pkg::S_YWAIT ||
                  state_q == mhg_pkg::S_LWAIT))
    else $error("divider result arrived unexpectedly");

  // An accepted request always starts work.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q != mhg_pkg::S_IDLE)
    else $error("accepted request left the controller idle");

  // With cells held, the height range is ordered.
  a_range_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (used_q != '0) |-> (lo_q <= hi_q))
    else $error("height range inverted while cells are held");

endmodule

/* sim/max_height_grid_cell_map_tb.sv */
// Self-checking testbench for the max-height grid cell map.
module max_height_grid_cell_map_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 3000000;
  localparam int unsigned IDLE_PCT    = 19;

  typedef struct {
    logic signed [15:0] ix;
    logic signed [15:0] iy;
    logic signed [31:0] height;
    logic [31:0]        color;
    logic [63:0]        node;
  } cell_t;

  logic clk_i = 1'b1;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  mhg_pkg::req_t in_req_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  mhg_pkg::rsp_t out_rsp_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [1:0] cfg_index_i = mhg_pkg::CFG_CELL_SIZE;
  logic [31:0] cfg_data_i = '0;

  // Testbench copy of the map and its registers.
  cell_t       map_cells[$];
  logic [20:0] cfg_cell_size;
  logic [12:0] cfg_max_cells;
  logic [31:0] cfg_default_color;
  logic signed [31:0] lowest_seen;
  logic signed [31:0] highest_seen;

  mhg_pkg::req_t pending_requests[$];
  mhg_pkg::rsp_t awaited_results[$];
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  bit          no_idling = 1'b0;

  max_height_grid_cell_map dut (.*);

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Run limit.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch in %s: got %h, expected %h", what, got, want);
    error_count++;
  endtask

  // Floor division of a coordinate by the cell size, saturated to the index range.
  function automatic logic signed [15:0] cell_index(input logic signed [31:0] coord);
    longint d;
    longint q;
    d = (cfg_cell_size < 21'd7) ? 3277 : longint'(cfg_cell_size);
    q = longint'(coord) / d;
    if (longint'(coord) % d != 0 && coord < 0) q--;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return 16'(q);
  endfunction

  function automatic logic signed [7:0] height_level(input logic signed [31:0] h);
    longint span;
    longint num;
    longint v;
    span = longint'(highest_seen) - longint'(lowest_seen);
    if (span < 66) span = 66;
    num = (longint'(h) - longint'(lowest_seen)) * 100;
    if (num <= 0) return 8'sd0;
    v = (2 * num + span) / (2 * span);
    if (v > 100) v = 100;
    return 8'(v);
  endfunction

  function automatic int find_cell(input logic signed [15:0] ix, input logic signed [15:0] iy);
    foreach (map_cells[i])
      if (map_cells[i].ix == ix && map_cells[i].iy == iy) return i;
    return -1;
  endfunction

  // Works out the result of one request and updates the map copy.
  function automatic mhg_pkg::rsp_t map_predict(input mhg_pkg::req_t rq);
    mhg_pkg::rsp_t r;
    int k;
    longint diff;
    logic signed [15:0] ix;
    logic signed [15:0] iy;
    cell_t c;
    r = '0;
    if (rq.func == mhg_pkg::FN_CLEAR) begin
      map_cells.delete();
      lowest_seen = 32'sh7FFFFFFF;
      highest_seen = 32'sh80000000;
      r.status = mhg_pkg::ST_CLEARED;
    end else if (rq.func == mhg_pkg::FN_INSERT) begin
      ix = cell_index(rq.point_x);
      iy = cell_index(rq.point_y);
      r.cell_ix = ix;
      r.cell_iy = iy;
      k = find_cell(ix, iy);
      if (k < 0 && (map_cells.size() >= cfg_max_cells ||
                    map_cells.size() >= mhg_pkg::CAPACITY)) begin
        r.status = mhg_pkg::ST_DROPPED;
        r.level = mhg_pkg::LEVEL_NONE;
      end else begin
        if (k < 0) begin
          c.ix = ix;
          c.iy = iy;
          c.height = rq.point_z;
          c.node = rq.source_node;
          c.color = (rq.point_color != 0) ? rq.point_color : cfg_default_color;
          map_cells.push_back(c);
          k = map_cells.size() - 1;
          r.status = mhg_pkg::ST_UPDATED;
        end else begin
          c = map_cells[k];
          diff = longint'(rq.point_z) - longint'(c.height);
          if (diff > 7 || (diff >= -7 && diff <= 7 && rq.source_node >= c.node)) begin
            c.height = rq.point_z;
            c.node = rq.source_node;
            if (rq.point_color != 0) c.color = rq.point_color;
            else if (c.color == 0) c.color = cfg_default_color;
            map_cells[k] = c;
            r.status = mhg_pkg::ST_UPDATED;
          end else begin
            r.status = mhg_pkg::ST_KEPT;
          end
        end
        if (rq.point_z < lowest_seen) lowest_seen = rq.point_z;
        if (rq.point_z > highest_seen) highest_seen = rq.point_z;
        r.level = height_level(c.height);
        r.cell_height = c.height;
        r.cell_color = c.color;
        r.cell_node = c.node;
      end
    end else begin
      // Query, and the spare code handled the same way.
      r.cell_ix = rq.query_ix;
      r.cell_iy = rq.query_iy;
      k = find_cell(rq.query_ix, rq.query_iy);
      if (k < 0) begin
        r.status = mhg_pkg::ST_MISS;
        r.level = mhg_pkg::LEVEL_NONE;
      end else begin
        r.status = mhg_pkg::ST_HIT;
        r.level = height_level(map_cells[k].height);
        r.cell_height = map_cells[k].height;
        r.cell_color = map_cells[k].color;
        r.cell_node = map_cells[k].node;
      end
    end
    r.cell_count = 13'(map_cells.size());
    r.height_min = lowest_seen;
    r.height_max = highest_seen;
    return r;
  endfunction

  // Request driver: predicts each accepted request and offers the next one.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) awaited_results.push_back(map_predict(in_req_i));
      if (!in_valid_i || !in_stall_o) begin
        if (pending_requests.size() != 0 &&
            (no_idling || $urandom_range(99) >= IDLE_PCT)) begin
          in_valid_i <= 1'b1;
          in_req_i <= pending_requests.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Result monitor with random stalls.
  always @(posedge clk_i or negedge rst_ni) begin
    mhg_pkg::rsp_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (awaited_results.size() == 0) begin
          report_mismatch("unexpected result", 64'(out_rsp_o.status), '0);
        end else begin
          want = awaited_results.pop_front();
          if (out_rsp_o.status !== want.status)
            report_mismatch("status", 64'(out_rsp_o.status), 64'(want.status));
          if (out_rsp_o.cell_ix !== want.cell_ix)
            report_mismatch("cell_ix", 64'(out_rsp_o.cell_ix), 64'(want.cell_ix));
          if (out_rsp_o.cell_iy !== want.cell_iy)
            report_mismatch("cell_iy", 64'(out_rsp_o.cell_iy), 64'(want.cell_iy));
          if (out_rsp_o.level !== want.level)
            report_mismatch("level", 64'(out_rsp_o.level), 64'(want.level));
          if (out_rsp_o.cell_height !== want.cell_height)
            report_mismatch("cell_height", 64'(out_rsp_o.cell_height), 64'(want.cell_height));
          if (out_rsp_o.cell_color !== want.cell_color)
            report_mismatch("cell_color", 64'(out_rsp_o.cell_color), 64'(want.cell_color));
          if (out_rsp_o.cell_node !== want.cell_node)
            report_mismatch("cell_node", out_rsp_o.cell_node, want.cell_node);
          if (out_rsp_o.cell_count !== want.cell_count)
            report_mismatch("cell_count", 64'(out_rsp_o.cell_count), 64'(want.cell_count));
          if (out_rsp_o.height_min !== want.height_min)
            report_mismatch("height_min", 64'(out_rsp_o.height_min), 64'(want.height_min));
          if (out_rsp_o.height_max !== want.height_max)
            report_mismatch("height_max", 64'(out_rsp_o.height_max), 64'(want.height_max));
        end
      end
      out_stall_i <= !no_idling && ($urandom_range(99) < IDLE_PCT);
    end
  end

  // Waits until every request has been answered and the block has settled.
  task automatic drain();
    do @(posedge clk_i);
    while (pending_requests.size() != 0 || in_valid_i || awaited_results.size() != 0);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_register(input mhg_pkg::cfg_idx_e idx, input logic [31:0] value);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      mhg_pkg::CFG_CELL_SIZE:     cfg_cell_size = value[20:0];
      mhg_pkg::CFG_MAX_CELLS:     cfg_max_cells = value[12:0];
      mhg_pkg::CFG_DEFAULT_COLOR: cfg_default_color = value;
      default: ;
    endcase
  endtask

  function automatic mhg_pkg::req_t random_fill();
    mhg_pkg::req_t rq;
    rq.func = mhg_pkg::FN_INSERT;
    rq.point_x = $urandom();
    rq.point_y = $urandom();
    rq.point_z = $urandom();
    rq.point_color = $urandom();
    rq.source_node = {$urandom(), $urandom()};
    rq.query_ix = $urandom();
    rq.query_iy = $urandom();
    return rq;
  endfunction

  function automatic mhg_pkg::req_t insert_point(input logic signed [31:0] x,
                                                 input logic signed [31:0] y,
                                                 input logic signed [31:0] z,
                                                 input logic [31:0] color,
                                                 input logic [63:0] node);
    mhg_pkg::req_t rq;
    rq = random_fill();
    rq.point_x = x;
    rq.point_y = y;
    rq.point_z = z;
    rq.point_color = color;
    rq.source_node = node;
    return rq;
  endfunction

  function automatic mhg_pkg::req_t plain_request(input mhg_pkg::func_e f,
                                                  input logic signed [15:0] qx,
                                                  input logic signed [15:0] qy);
    mhg_pkg::req_t rq;
    rq = random_fill();
    rq.func = f;
    rq.query_ix = qx;
    rq.query_iy = qy;
    return rq;
  endfunction

  // Coordinate inside one of a few cells around the origin, or anywhere at all.
  function automatic logic signed [31:0] near_coord(input int c);
    longint d;
    d = (cfg_cell_size < 21'd7) ? 3277 : longint'(cfg_cell_size);
    if ($urandom_range(19) == 0) return $urandom();
    return 32'(longint'(c) * d + longint'($urandom_range(int'(d - 1))));
  endfunction

  // Mostly inserts into a small cluster of cells with heights close together,
  // queries of that cluster, and now and then a clear or a stray request.
  task automatic queue_random(input int unsigned count);
    mhg_pkg::req_t rq;
    int unsigned sel;
    int cx;
    int cy;
    logic signed [31:0] base_z;
    base_z = $urandom();
    base_z = base_z >>> 8;
    repeat (count) begin
      sel = $urandom_range(99);
      cx = $urandom_range(7) - 4;
      cy = $urandom_range(7) - 4;
      if (sel < 65) begin
        rq = random_fill();
        rq.point_x = near_coord(cx);
        rq.point_y = near_coord(cy);
        case ($urandom_range(3))
          0: rq.point_z = base_z + $signed($urandom_range(30)) - 15;
          1: rq.point_z = base_z + $signed($urandom_range(2000)) - 1000;
          2: rq.point_z = $urandom();
          default: rq.point_z = base_z + $signed($urandom_range(100000)) - 50000;
        endcase
        if ($urandom_range(2) == 0) rq.point_color = '0;
        if ($urandom_range(1) == 0) rq.source_node = 64'($urandom_range(3));
      end else if (sel < 92) begin
        if ($urandom_range(3) == 0) begin
          rq = plain_request(mhg_pkg::FN_QUERY, $urandom(), $urandom());
        end else begin
          rq = plain_request(mhg_pkg::FN_QUERY, 16'(cx), 16'(cy));
        end
      end else if (sel < 95) begin
        rq = plain_request(mhg_pkg::FN_SPARE, 16'(cx), 16'(cy));
      end else begin
        rq = plain_request(mhg_pkg::FN_CLEAR, '0, '0);
      end
      pending_requests.push_back(rq);
    end
  endtask

  initial begin
    cfg_cell_size = mhg_pkg::FALLBACK_CELL;
    cfg_max_cells = mhg_pkg::RESET_MAX_CELLS;
    cfg_default_color = '0;
    lowest_seen = 32'sh7FFFFFFF;
    highest_seen = 32'sh80000000;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed requests under the reset settings.
    pending_requests.push_back(plain_request(mhg_pkg::FN_QUERY, 16'sh7FFF, 16'sh8000));
    pending_requests.push_back(insert_point(32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF,
                                            '0, '1));
    pending_requests.push_back(insert_point(32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000,
                                            32'hFFFFFFFF, '0));
    pending_requests.push_back(insert_point(100, -1, 1000, 32'h00123456, 64'd5));
    pending_requests.push_back(insert_point(200, -3000, 1007, '0, 64'd5));
    pending_requests.push_back(insert_point(300, -5, 1000, 32'hABCDEF01, 64'd4));
    pending_requests.push_back(insert_point(300, -5, 993, '0, 64'd6));
    pending_requests.push_back(insert_point(300, -5, 985, 32'h1, 64'd9));
    pending_requests.push_back(insert_point(300, -5, 1001, 32'h2, '1));
    pending_requests.push_back(insert_point(0, 0, 0, 32'h3, 64'd1));
    pending_requests.push_back(insert_point(-3277, 3276, -50, '0, 64'd1));
    pending_requests.push_back(plain_request(mhg_pkg::FN_QUERY, 16'sd0, -16'sd1));
    pending_requests.push_back(plain_request(mhg_pkg::FN_QUERY, 16'sd0, 16'sd0));
    pending_requests.push_back(plain_request(mhg_pkg::FN_SPARE, -16'sd1, 16'sd0));
    pending_requests.push_back(plain_request(mhg_pkg::FN_QUERY, 16'sd5, 16'sd5));
    pending_requests.push_back(plain_request(mhg_pkg::FN_CLEAR, '0, '0));
    pending_requests.push_back(plain_request(mhg_pkg::FN_QUERY, 16'sd0, 16'sd0));
    pending_requests.push_back(insert_point(-1, -1, -7, '0, '0));
    drain();

    // Empty table allowed: every insert dropped. Smallest cell size.
    write_register(mhg_pkg::CFG_CELL_SIZE, 32'd7);
    write_register(mhg_pkg::CFG_MAX_CELLS, 32'd0);
    write_register(mhg_pkg::CFG_DEFAULT_COLOR, 32'hFFFFFFFF);
    write_register(mhg_pkg::CFG_UNUSED, 32'hFFFFFFFF);
    pending_requests.push_back(insert_point(-8, 13, 55, '0, 64'd1));
    pending_requests.push_back(plain_request(mhg_pkg::FN_QUERY, -16'sd2, 16'sd1));
    queue_random(20);
    drain();

    // Small table with a cell size below the minimum, which falls back.
    write_register(mhg_pkg::CFG_CELL_SIZE, 32'hFFE00003);
    write_register(mhg_pkg::CFG_MAX_CELLS, 32'd12);
    pending_requests.push_back(plain_request(mhg_pkg::FN_CLEAR, '0, '0));
    queue_random(400);
    drain();

    // Largest cell size, no idling for a while.
    write_register(mhg_pkg::CFG_CELL_SIZE, 32'h001FFFFF);
    write_register(mhg_pkg::CFG_MAX_CELLS, 32'd4096);
    write_register(mhg_pkg::CFG_DEFAULT_COLOR, 32'd0);
    no_idling = 1'b1;
    queue_random(200);
    drain();
    no_idling = 1'b0;

    write_register(mhg_pkg::CFG_CELL_SIZE, 32'd1048576);
    write_register(mhg_pkg::CFG_MAX_CELLS, 32'd40);
    write_register(mhg_pkg::CFG_DEFAULT_COLOR, $urandom());
    queue_random(400);
    drain();

    // Random settings.
    repeat (3) begin
      write_register(mhg_pkg::CFG_CELL_SIZE, $urandom_range(7, 70000));
      write_register(mhg_pkg::CFG_MAX_CELLS, $urandom_range(1, 64));
      write_register(mhg_pkg::CFG_DEFAULT_COLOR, $urandom());
      queue_random(280);
      drain();
    end

    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
